FILE: src/assert_macros.svh
// Assertion macros for the global average pooling block.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/gap_pkg.sv
// Shared types and constants for the global average pooling block.
// No dependencies.
`default_nettype none

package gap_pkg;

    localparam int SEQ_LEN_W  = 11;
    localparam int FEAT_CNT_W = 9;
    localparam int RECIP_W    = 17;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 17;
    localparam int IDX_OUT_W  = 8;
    localparam int FRAC_W     = 16;

    localparam logic [SEQ_LEN_W-1:0]  SEQ_LEN_RESET  = SEQ_LEN_W'(1);
    localparam logic [FEAT_CNT_W-1:0] FEAT_CNT_RESET = FEAT_CNT_W'(1);
    localparam logic [RECIP_W-1:0]    RECIP_RESET    = RECIP_W'(65536);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SEQ_LENGTH     = 2'd0,
        REG_FEATURE_COUNT  = 2'd1,
        REG_SEQ_RECIPROCAL = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic last_row;
        logic last_feat;
    } t_gap_ctl;

endpackage

`default_nettype wire

FILE: src/gap_fifo.sv
// Small synchronous queue of generic width, power-of-two depth.
// No package dependencies.
`default_nettype none

module gap_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic [WIDTH-1:0]      o_data,
    output logic                  o_empty
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [AW:0]      r_count,  n_count;
    logic             w_do_push, w_do_pop;

    assign o_full    = (r_count == (AW+1)'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_data    = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = w_do_push ? r_wr_ptr + AW'(1) : r_wr_ptr;
        n_rd_ptr = w_do_pop  ? r_rd_ptr + AW'(1) : r_rd_ptr;
        n_count  = r_count;
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + (AW+1)'(1);
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - (AW+1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

FILE: src/gap_front.sv
// Front end: feature and position counters, classifies each accepted item.
// Depends on gap_pkg.
`default_nettype none

module gap_front #(
    parameter int MAX_FEATURES = 256,
    parameter int MAX_SEQ      = 1024,
    parameter int FW           = 8,
    parameter int PW           = 10
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [gap_pkg::SEQ_LEN_W-1:0]  i_seq_length,
    input  wire logic [gap_pkg::FEAT_CNT_W-1:0] i_feature_count,
    input  wire logic                           i_accept,
    output logic [FW-1:0]                       o_idx,
    output gap_pkg::t_gap_ctl                   o_ctl
);
    import gap_pkg::*;

    localparam int ES_W = (SEQ_LEN_W > PW + 1) ? SEQ_LEN_W : PW + 1;
    localparam int EF_W = (FEAT_CNT_W > FW + 1) ? FEAT_CNT_W : FW + 1;

    logic [FW-1:0]   r_feat_cnt, n_feat_cnt;
    logic [PW-1:0]   r_pos_cnt,  n_pos_cnt;
    logic [ES_W-1:0] w_seq_ext, w_eff_seq, w_pos_next;
    logic [EF_W-1:0] w_feat_ext, w_eff_feat, w_feat_next;

    always_comb begin
        w_seq_ext = ES_W'(i_seq_length);
        if (w_seq_ext == '0) begin
            w_eff_seq = ES_W'(1);
        end else if (w_seq_ext > ES_W'(MAX_SEQ)) begin
            w_eff_seq = ES_W'(MAX_SEQ);
        end else begin
            w_eff_seq = w_seq_ext;
        end

        w_feat_ext = EF_W'(i_feature_count);
        if (w_feat_ext == '0) begin
            w_eff_feat = EF_W'(1);
        end else if (w_feat_ext > EF_W'(MAX_FEATURES)) begin
            w_eff_feat = EF_W'(MAX_FEATURES);
        end else begin
            w_eff_feat = w_feat_ext;
        end

        w_pos_next  = ES_W'(r_pos_cnt) + ES_W'(1);
        w_feat_next = EF_W'(r_feat_cnt) + EF_W'(1);

        o_ctl.last_row  = (w_pos_next >= w_eff_seq);
        o_ctl.last_feat = (w_feat_next >= w_eff_feat);
        o_idx           = r_feat_cnt;

        n_feat_cnt = r_feat_cnt;
        n_pos_cnt  = r_pos_cnt;
        if (i_accept) begin
            if (o_ctl.last_feat) begin
                n_feat_cnt = '0;
                n_pos_cnt  = o_ctl.last_row ? '0 : PW'(w_pos_next);
            end else begin
                n_feat_cnt = FW'(w_feat_next);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_feat_cnt <= '0;
            r_pos_cnt  <= '0;
        end else begin
            r_feat_cnt <= n_feat_cnt;
            r_pos_cnt  <= n_pos_cnt;
        end
    end

endmodule

`default_nettype wire

FILE: src/gap_back.sv
// Back end: per-feature sum memory with read-modify-write, scaling multiply,
// floor shift and saturation. Depends on gap_pkg.
`default_nettype none

module gap_back #(
    parameter int MAX_FEATURES = 256,
    parameter int SAMPLE_BITS  = 16,
    parameter int FW           = 8,
    parameter int SUM_W        = 26,
    parameter int RES_DEPTH    = 8
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic [gap_pkg::RECIP_W-1:0]         i_recip,
    input  wire logic                                i_q_empty,
    input  wire logic signed [SAMPLE_BITS-1:0]       i_q_sample,
    input  wire logic [FW-1:0]                       i_q_idx,
    input  wire gap_pkg::t_gap_ctl                   i_q_ctl,
    output logic                                     o_q_pop,
    output logic                                     o_res_push,
    output logic signed [SAMPLE_BITS-1:0]            o_res_mean,
    output logic [gap_pkg::IDX_OUT_W-1:0]            o_res_idx,
    output logic                                     o_res_last,
    input  wire logic                                i_res_pop
);
    import gap_pkg::*;

    localparam int PROD_W = SUM_W + RECIP_W + 1;
    localparam int CW     = $clog2(RES_DEPTH + 1);

    logic [SUM_W-1:0]              r_sum_mem [MAX_FEATURES];
    logic [MAX_FEATURES-1:0]       r_sum_ok;

    logic                          r_b2_vld;
    logic signed [SAMPLE_BITS-1:0] r_b2_sample;
    logic [FW-1:0]                 r_b2_idx;
    t_gap_ctl                      r_b2_ctl;
    logic [SUM_W-1:0]              r_rd_raw;
    logic                          r_rd_ok;
    logic                          r_fwd;
    logic [SUM_W-1:0]              r_fwd_data;

    logic                          r_b3_vld;
    logic signed [SUM_W-1:0]       r_b3_total;
    logic [IDX_OUT_W-1:0]          r_b3_idx;
    logic                          r_b3_last;

    logic                          r_b4_vld;
    logic signed [PROD_W-1:0]      r_b4_prod;
    logic [IDX_OUT_W-1:0]          r_b4_idx;
    logic                          r_b4_last;

    logic [CW-1:0]                 r_credit, n_credit;

    logic                          w_credit_ok, w_b2_leave, w_b2_load, w_we;
    logic signed [SUM_W-1:0]       w_b2_sum, w_total;
    logic [SUM_W-1:0]              w_wdata;
    logic signed [PROD_W-1:0]      w_prod, w_shift;
    logic [PROD_W-SAMPLE_BITS:0]   w_top;

    assign w_credit_ok = (r_credit < CW'(RES_DEPTH));
    assign w_b2_leave  = r_b2_vld && (!r_b2_ctl.last_row || w_credit_ok);
    assign w_b2_load   = !i_q_empty && (!r_b2_vld || w_b2_leave);
    assign o_q_pop     = w_b2_load;

    assign w_b2_sum = r_fwd ? r_fwd_data : (r_rd_ok ? r_rd_raw : '0);
    assign w_total  = w_b2_sum + SUM_W'(r_b2_sample);
    assign w_we     = w_b2_leave;
    assign w_wdata  = r_b2_ctl.last_row ? '0 : w_total;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_sum_mem[r_b2_idx] <= w_wdata;
        end
        if (w_b2_load) begin
            r_rd_raw <= r_sum_mem[i_q_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_ok <= '0;
            r_b2_vld <= 1'b0;
            r_b3_vld <= 1'b0;
            r_b4_vld <= 1'b0;
            r_credit <= '0;
        end else begin
            if (w_we) begin
                r_sum_ok[r_b2_idx] <= 1'b1;
            end
            r_b2_vld <= w_b2_load || (r_b2_vld && !w_b2_leave);
            r_b3_vld <= w_b2_leave && r_b2_ctl.last_row;
            r_b4_vld <= r_b3_vld;
            r_credit <= n_credit;
        end
    end

    always_comb begin
        n_credit = r_credit;
        if ((w_b2_leave && r_b2_ctl.last_row) && !i_res_pop) begin
            n_credit = r_credit + CW'(1);
        end else if (!(w_b2_leave && r_b2_ctl.last_row) && i_res_pop) begin
            n_credit = r_credit - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b2_load) begin
            r_b2_sample <= i_q_sample;
            r_b2_idx    <= i_q_idx;
            r_b2_ctl    <= i_q_ctl;
            r_rd_ok     <= r_sum_ok[i_q_idx];
            r_fwd       <= w_we && (r_b2_idx == i_q_idx);
            r_fwd_data  <= w_wdata;
        end
        r_b3_total <= w_total;
        r_b3_idx   <= IDX_OUT_W'(r_b2_idx);
        r_b3_last  <= r_b2_ctl.last_feat;
        r_b4_prod  <= w_prod;
        r_b4_idx   <= r_b3_idx;
        r_b4_last  <= r_b3_last;
    end

    assign w_prod = r_b3_total * $signed({1'b0, i_recip});

    always_comb begin
        w_shift = r_b4_prod >>> FRAC_W;
        w_top   = w_shift[PROD_W-1:SAMPLE_BITS-1];
        if ((&w_top) || !(|w_top)) begin
            o_res_mean = w_shift[SAMPLE_BITS-1:0];
        end else if (w_shift[PROD_W-1]) begin
            o_res_mean = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            o_res_mean = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

    assign o_res_push = r_b4_vld;
    assign o_res_idx  = r_b4_idx;
    assign o_res_last = r_b4_last;

endmodule

`default_nettype wire

FILE: src/global_average_pool_top.sv
// Global average pooling over the sequence axis: samples stream in row-major order
// (feature fastest), one running sum per feature is kept in an internal memory, and
// every sample on the last sequence row yields that feature's mean (sum times the
// configured Q1.16 reciprocal, floor-shifted by 16, saturated) and clears the sum.
// The block takes one sample per cycle while result-queue space is available; a
// result is pushed to the output queue after passing the input queue, the sum
// memory read-modify-write stage (same-feature back-to-back updates are forwarded),
// the multiply stage and the saturation stage. The sum memory needs no clearing
// pass: per-feature valid bits clear at reset. A 4-entry input queue and an
// 8-entry result queue let either side stall independently.
// Depends on gap_pkg, gap_fifo, gap_front, gap_back and assert_macros.svh.
`default_nettype none

module global_average_pool_top #(
    parameter int MAX_FEATURES = 256,
    parameter int MAX_SEQ      = 1024,
    parameter int SAMPLE_BITS  = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [gap_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [gap_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  wire logic                            push,
    output logic                                 full,
    input  wire logic signed [SAMPLE_BITS-1:0]   i_sample,
    output logic                                 empty,
    input  wire logic                            pop,
    output logic signed [SAMPLE_BITS-1:0]        o_mean_value,
    output logic [gap_pkg::IDX_OUT_W-1:0]        o_feature_index,
    output logic                                 o_last_of_batch
);
    import gap_pkg::*;

    `include "assert_macros.svh"

    localparam int FW        = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int PW        = (MAX_SEQ > 1) ? $clog2(MAX_SEQ) : 1;
    localparam int SUM_W     = SAMPLE_BITS + $clog2(MAX_SEQ);
    localparam int IN_DEPTH  = 4;
    localparam int RES_DEPTH = 8;
    localparam int IN_W      = SAMPLE_BITS + FW + 2;
    localparam int RES_W     = SAMPLE_BITS + IDX_OUT_W + 1;

    logic [SEQ_LEN_W-1:0]  r_seq_length;
    logic [FEAT_CNT_W-1:0] r_feature_count;
    logic [RECIP_W-1:0]    r_seq_recip;

    logic                          w_in_accept;
    logic [FW-1:0]                 w_idx;
    t_gap_ctl                      w_ctl;
    logic [IN_W-1:0]               w_in_entry, w_q_data;
    logic                          w_q_empty, w_q_pop;
    logic signed [SAMPLE_BITS-1:0] w_q_sample;
    logic [FW-1:0]                 w_q_idx;
    t_gap_ctl                      w_q_ctl;

    logic                          w_res_push, w_res_full, w_res_last, w_res_pop;
    logic signed [SAMPLE_BITS-1:0] w_res_mean;
    logic [IDX_OUT_W-1:0]          w_res_idx;
    logic [RES_W-1:0]              w_res_entry, w_res_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq_length    <= SEQ_LEN_RESET;
            r_feature_count <= FEAT_CNT_RESET;
            r_seq_recip     <= RECIP_RESET;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_addr))
                REG_SEQ_LENGTH: begin
                    r_seq_length <= i_cfg_wdata[SEQ_LEN_W-1:0];
                end
                REG_FEATURE_COUNT: begin
                    r_feature_count <= i_cfg_wdata[FEAT_CNT_W-1:0];
                end
                REG_SEQ_RECIPROCAL: begin
                    r_seq_recip <= i_cfg_wdata[RECIP_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign w_in_accept = push && !full;

    gap_front #(
        .MAX_FEATURES (MAX_FEATURES),
        .MAX_SEQ      (MAX_SEQ),
        .FW           (FW),
        .PW           (PW)
    ) u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_seq_length    (r_seq_length),
        .i_feature_count (r_feature_count),
        .i_accept        (w_in_accept),
        .o_idx           (w_idx),
        .o_ctl           (w_ctl)
    );

    assign w_in_entry = {i_sample, w_idx, w_ctl};

    gap_fifo #(
        .WIDTH (IN_W),
        .DEPTH (IN_DEPTH)
    ) u_in_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (w_in_entry),
        .o_full  (full),
        .i_pop   (w_q_pop),
        .o_data  (w_q_data),
        .o_empty (w_q_empty)
    );

    assign w_q_sample = w_q_data[IN_W-1 -: SAMPLE_BITS];
    assign w_q_idx    = w_q_data[FW+1:2];
    assign w_q_ctl    = w_q_data[1:0];

    gap_back #(
        .MAX_FEATURES (MAX_FEATURES),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .FW           (FW),
        .SUM_W        (SUM_W),
        .RES_DEPTH    (RES_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_recip    (r_seq_recip),
        .i_q_empty  (w_q_empty),
        .i_q_sample (w_q_sample),
        .i_q_idx    (w_q_idx),
        .i_q_ctl    (w_q_ctl),
        .o_q_pop    (w_q_pop),
        .o_res_push (w_res_push),
        .o_res_mean (w_res_mean),
        .o_res_idx  (w_res_idx),
        .o_res_last (w_res_last),
        .i_res_pop  (w_res_pop)
    );

    assign w_res_entry = {w_res_mean, w_res_idx, w_res_last};
    assign w_res_pop   = pop && !empty;

    gap_fifo #(
        .WIDTH (RES_W),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_push),
        .i_data  (w_res_entry),
        .o_full  (w_res_full),
        .i_pop   (pop),
        .o_data  (w_res_data),
        .o_empty (empty)
    );

    assign o_mean_value    = w_res_data[RES_W-1 -: SAMPLE_BITS];
    assign o_feature_index = w_res_data[IDX_OUT_W:1];
    assign o_last_of_batch = w_res_data[0];

    `ASSERT_IMPLY(a_res_no_overflow, i_clk, i_rst_n, w_res_push, !w_res_full,
        "result pushed into full result queue")
    `ASSERT_NEXT(a_feat_advance, i_clk, i_rst_n, i_rst_n && w_in_accept && !w_ctl.last_feat,
        w_idx == FW'($past(w_idx) + FW'(1)), "feature counter did not advance")
    `ASSERT_NEXT(a_feat_wrap, i_clk, i_rst_n, i_rst_n && w_in_accept && w_ctl.last_feat,
        w_idx == '0, "feature counter did not wrap after last feature")

endmodule

`default_nettype wire

FILE: tb/global_average_pool_top_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for global_average_pool_top: streams batches of samples with
// random gaps and stalls, predicts each feature mean and checks every popped item in order.
// Depends on gap_pkg and the global_average_pool_top RTL.

module global_average_pool_top_tb;
    import gap_pkg::*;

    localparam int SAMPLE_W      = 16;
    localparam int MAX_FEAT      = 256;
    localparam int MAX_ROWS      = 1024;
    localparam int SETTLE_CYCLES = 8;
    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int RANDOM_ITEMS  = 400;
    localparam int PRINT_LIMIT   = 40;
    localparam longint SAT_HI    = 32767;
    localparam longint SAT_LO    = -32768;

    typedef struct {
        logic signed [SAMPLE_W-1:0] mean_value;
        logic [IDX_OUT_W-1:0]       feature_index;
        logic                       last_of_batch;
    } mean_result_t;

    logic                        i_clk       = 1'b0;
    logic                        i_rst_n     = 1'b0;
    logic                        i_cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0]       i_cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]       i_cfg_wdata = '0;
    logic                        push        = 1'b0;
    logic                        full;
    logic signed [SAMPLE_W-1:0]  i_sample    = '0;
    logic                        empty;
    logic                        pop         = 1'b0;
    logic signed [SAMPLE_W-1:0]  o_mean_value;
    logic [IDX_OUT_W-1:0]        o_feature_index;
    logic                        o_last_of_batch;

    // predicted block state
    int unsigned  seq_length_q    = SEQ_LEN_RESET;
    int unsigned  feature_count_q = FEAT_CNT_RESET;
    int unsigned  reciprocal_q    = RECIP_RESET;
    int unsigned  feature_q       = 0;
    int unsigned  position_q      = 0;
    longint       feature_sums [MAX_FEAT];
    mean_result_t pending_means [$];

    int mismatches    = 0;
    int items_sent    = 0;
    int means_checked = 0;
    int reg_writes    = 0;
    int stall_hold    = 0;
    int burst_left    = 0;
    bit steady_sender = 1'b0;
    int cycle_count   = 0;

    global_average_pool_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_wdata     (i_cfg_wdata),
        .push            (push),
        .full            (full),
        .i_sample        (i_sample),
        .empty           (empty),
        .pop             (pop),
        .o_mean_value    (o_mean_value),
        .o_feature_index (o_feature_index),
        .o_last_of_batch (o_last_of_batch)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin : watchdog
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d means outstanding", cycle_count,
                 pending_means.size());
        $display("end of test: mismatches");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_LIMIT) begin
            $display("[%0t] %s", $time, msg);
        end
        mismatches++;
    endtask

    // sum update for one accepted sample; queues the mean on a last-row sample
    function automatic void accumulate_sample(input logic signed [SAMPLE_W-1:0] x);
        int unsigned  eff_seq;
        int unsigned  eff_feat;
        bit           at_last_row;
        bit           at_last_feat;
        longint       total;
        longint       scaled;
        mean_result_t r;
        eff_seq  = (seq_length_q == 0) ? 1 :
                   ((seq_length_q > MAX_ROWS) ? MAX_ROWS : seq_length_q);
        eff_feat = (feature_count_q == 0) ? 1 :
                   ((feature_count_q > MAX_FEAT) ? MAX_FEAT : feature_count_q);
        at_last_row  = (position_q + 1) >= eff_seq;
        at_last_feat = (feature_q + 1) >= eff_feat;
        if (at_last_row) begin
            total  = feature_sums[feature_q] + longint'(x);
            scaled = (total * longint'(reciprocal_q)) >>> FRAC_W;
            if (scaled > SAT_HI) begin
                scaled = SAT_HI;
            end else if (scaled < SAT_LO) begin
                scaled = SAT_LO;
            end
            r.mean_value    = scaled[SAMPLE_W-1:0];
            r.feature_index = feature_q[IDX_OUT_W-1:0];
            r.last_of_batch = at_last_feat;
            pending_means.push_back(r);
            feature_sums[feature_q] = 0;
        end else begin
            feature_sums[feature_q] += longint'(x);
        end
        if (at_last_feat) begin
            feature_q  = 0;
            position_q = at_last_row ? 0 : position_q + 1;
        end else begin
            feature_q++;
        end
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rand_sample();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return SAMPLE_W'($urandom_range(0, 512)) - SAMPLE_W'(256);
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    function automatic int next_gap();
        if (steady_sender) begin
            return 0;
        end
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        burst_left = $urandom_range(1, 24);
        return $urandom_range(1, 6);
    endfunction

    task automatic send_item(input logic signed [SAMPLE_W-1:0] value);
        int gap;
        @(negedge i_clk);
        push     <= 1'b1;
        i_sample <= value;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        accumulate_sample(value);
        items_sent++;
        gap = next_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // stop sending, let every expected mean drain, then let the pipeline settle
    task automatic wait_idle();
        @(negedge i_clk);
        push <= 1'b0;
        while (pending_means.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg which, input int unsigned value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= which;
        i_cfg_wdata <= CFG_DATA_W'(value);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (which)
            REG_SEQ_LENGTH:    seq_length_q    = value % (1 << SEQ_LEN_W);
            REG_FEATURE_COUNT: feature_count_q = value % (1 << FEAT_CNT_W);
            default:           reciprocal_q    = value % (1 << RECIP_W);
        endcase
        reg_writes++;
    endtask

    task automatic configure(input int unsigned seq_len, input int unsigned feat_cnt,
                             input int unsigned recip);
        write_reg(REG_SEQ_LENGTH, seq_len);
        write_reg(REG_FEATURE_COUNT, feat_cnt);
        write_reg(REG_SEQ_RECIPROCAL, recip);
    endtask

    task automatic test_directed_cases();
        // reset settings: each sample is its own mean
        send_item(16'sh7FFF);
        send_item(16'sh8000);
        send_item(16'sh0000);
        send_item(16'sh0001);
        send_item(16'shFFFF);
        send_item(16'sh5555);
        send_item(16'shAAAA);
        wait_idle();
        configure(1, 1, 0);
        send_item(16'sh1234);
        wait_idle();
        write_reg(REG_SEQ_RECIPROCAL, (1 << RECIP_W) - 1);
        send_item(16'sh0064);
        send_item(16'sh8000);
        wait_idle();
        // negative half rounds toward minus infinity
        configure(2, 1, 32768);
        send_item(16'shFFFF);
        send_item(16'sh0000);
        wait_idle();
        configure(2, 1, 65536);
        send_item(16'sh7FFF);
        send_item(16'sh7FFF);
        send_item(16'sh8000);
        send_item(16'sh8000);
        wait_idle();
        // zero length and count act as one
        configure(0, 0, 65536);
        send_item(16'sh0100);
        send_item(16'shFF00);
        wait_idle();
        // shrink count, then length, in the middle of a batch
        configure(3, 3, 21845);
        repeat (4) send_item(rand_sample());
        wait_idle();
        write_reg(REG_FEATURE_COUNT, 1);
        send_item(rand_sample());
        wait_idle();
        write_reg(REG_SEQ_LENGTH, 2);
        send_item(rand_sample());
        send_item(rand_sample());
    endtask

    task automatic test_size_limits();
        wait_idle();
        configure(1, 1, 65536);
        send_item(16'sh0000);
        wait_idle();
        // oversized length clamps to the deepest sequence, full-scale sum
        configure((1 << SEQ_LEN_W) - 1, 1, 64);
        repeat (MAX_ROWS) send_item(16'sh8000);
        wait_idle();
        // oversized count clamps to the widest row
        configure(1, (1 << FEAT_CNT_W) - 1, 65536);
        repeat (MAX_FEAT) send_item(rand_sample());
    endtask

    task automatic test_backpressure();
        wait_idle();
        configure(1, 4, 65536);
        steady_sender = 1'b1;
        stall_hold    = 300;
        repeat (60) send_item(rand_sample());
        steady_sender = 1'b0;
        wait_idle();
        stall_hold = 120;
        repeat (40) send_item(rand_sample());
    endtask

    task automatic test_random_batches();
        int          target;
        int unsigned seq_len;
        int unsigned feat_cnt;
        int unsigned recip;
        int          count;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            wait_idle();
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: seq_len = $urandom_range(1, 4);
                6, 7, 8:          seq_len = $urandom_range(5, 16);
                default:          seq_len = $urandom_range(17, 40);
            endcase
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: feat_cnt = $urandom_range(1, 8);
                6, 7, 8:          feat_cnt = $urandom_range(9, 24);
                default:          feat_cnt = (seq_len <= 2) ? $urandom_range(100, 256)
                                                            : $urandom_range(25, 40);
            endcase
            case ($urandom_range(0, 9))
                7, 8:    recip = $urandom_range(0, 65536);
                9:       recip = 65536;
                default: recip = (65536 + seq_len / 2) / seq_len;
            endcase
            steady_sender = ($urandom_range(0, 3) == 0);
            configure(seq_len, feat_cnt, recip);
            count = seq_len * feat_cnt * ((seq_len * feat_cnt > 200) ? 1 : $urandom_range(1, 3));
            // broken batch: counters carry over into the next setting
            if ($urandom_range(0, 4) == 0) begin
                count += $urandom_range(1, seq_len * feat_cnt);
            end
            repeat (count) send_item(rand_sample());
        end
        steady_sender = 1'b0;
    endtask

    initial begin : receiver
        int mode_left;
        int pop_pct;
        mode_left = 0;
        pop_pct   = 100;
        forever begin
            @(negedge i_clk);
            if (stall_hold > 0) begin
                stall_hold--;
                pop <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode_left = $urandom_range(10, 80);
                    case ($urandom_range(0, 4))
                        0, 1:    pop_pct = 100;
                        2:       pop_pct = 70;
                        3:       pop_pct = 45;
                        default: pop_pct = 20;
                    endcase
                end
                mode_left--;
                pop <= ($urandom_range(0, 99) < pop_pct);
            end
        end
    end

    always @(posedge i_clk) begin : mean_checker
        mean_result_t want;
        if (i_rst_n && pop && !empty) begin
            if (pending_means.size() == 0) begin
                report_mismatch($sformatf("unexpected item: feature %0d mean %0d last %0b",
                                          o_feature_index, o_mean_value, o_last_of_batch));
            end else begin
                want = pending_means.pop_front();
                means_checked++;
                if (o_mean_value !== want.mean_value) begin
                    report_mismatch($sformatf("feature %0d: mean %0d, expected %0d",
                                              want.feature_index, o_mean_value,
                                              want.mean_value));
                end
                if (o_feature_index !== want.feature_index) begin
                    report_mismatch($sformatf("feature index %0d, expected %0d",
                                              o_feature_index, want.feature_index));
                end
                if (o_last_of_batch !== want.last_of_batch) begin
                    report_mismatch($sformatf("feature %0d: last_of_batch %0b, expected %0b",
                                              want.feature_index, o_last_of_batch,
                                              want.last_of_batch));
                end
            end
        end
    end

    initial begin : main
        foreach (feature_sums[i]) feature_sums[i] = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed_cases();
        test_size_limits();
        test_backpressure();
        test_random_batches();
        wait_idle();
        $display("sent %0d samples, checked %0d means, made %0d register writes",
                 items_sent, means_checked, reg_writes);
        $display("lengths and counts from zero to past their limits, reciprocals up to max");
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+src
src/gap_pkg.sv
src/gap_fifo.sv
src/gap_front.sv
src/gap_back.sv
src/global_average_pool_top.sv
tb/global_average_pool_top_tb.sv
